FILE: src/vdu_pkg.sv
// ----------------------------------------------------------------------------
// vdu_pkg: shared types and constants of the vector distance unit
// Widths of elements, accumulators and the final-stage request record.
// ----------------------------------------------------------------------------
package vdu_pkg;

	localparam int MaxLength = 1024;
	localparam int ElemBits  = 16;
	localparam int LenBits   = 11;
	localparam int CntBits   = 10;
	localparam int DotBits   = 42;
	localparam int NormBits  = 41;
	localparam int SqBits    = 43;
	localparam int DistBits  = 43;
	localparam int ProdBits  = 2 * NormBits;
	localparam int RootBits  = NormBits;
	localparam int QuotBits  = 41;
	localparam int RegIdxBits = 1;
	localparam int CfgDataBits = 11;

	localparam logic [RegIdxBits-1:0] REG_USE_COSINE    = 1'b0;
	localparam logic [RegIdxBits-1:0] REG_VECTOR_LENGTH = 1'b1;

	localparam logic [ProdBits-1:0] DegenLimit = ProdBits'(116);
	localparam logic [QuotBits-1:0] QCap = QuotBits'(1) << 40;
	localparam logic [DistBits-1:0] OneQ30 = DistBits'(1) << 30;
	localparam logic [DistBits-1:0] TwoQ30 = DistBits'(1) << 31;

	// one finished vector handed from the accumulator to the finisher
	typedef struct packed {
		logic                       cosine;
		logic signed [DotBits-1:0]  dot;
		logic [NormBits-1:0]        norm_a;
		logic [NormBits-1:0]        norm_b;
		logic [SqBits-1:0]          sq;
	} vec_req_t;

endpackage

FILE: src/vector_distance_unit.sv
// Cosine requests step through multiply, root and divide (4 multiply, 41 root,
// 72 divide steps), leaving the root early when the norms are degenerate.
// Throughput: one element pair per cycle while full is low; the back takes a new
// request only after the last result is popped; squared-L2 skips the steps;
// full rises once the two-entry request queue cannot take another vector.
// Reset: asynchronous, active low; accumulators, count and queues clear,
// use_cosine = 0, vector_length = 128.
// ----------------------------------------------------------------------------
// vector_distance_unit: streaming cosine / squared-L2 distance
// Accumulator front, request queue, and a sequenced root/divide back end.
// ----------------------------------------------------------------------------
module vector_distance_unit import vdu_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [ElemBits-1:0] a_elem,
	input  logic signed [ElemBits-1:0] b_elem,
	output logic                       empty,
	input  logic                       pop,
	output logic [DistBits-1:0]        dist_value,
	output logic                       degenerate,
	input  logic                       cfg_we,
	input  logic [RegIdxBits-1:0]      cfg_index,
	input  logic [CfgDataBits-1:0]     cfg_data
);
	logic               use_cosine_q;
	logic [LenBits-1:0] vector_length_q;
	logic               req_valid, req_take;
	vec_req_t           req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_cosine_q <= 1'b0;
			vector_length_q <= LenBits'(128);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_USE_COSINE: use_cosine_q <= cfg_data[0];
				REG_VECTOR_LENGTH: vector_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	vdu_front u_front (.clk, .arst_n, .push, .full, .a_elem, .b_elem,
		.use_cosine(use_cosine_q), .vector_length(vector_length_q),
		.req_valid, .req, .req_take);

	vdu_back u_back (.clk, .arst_n, .req_valid, .req, .req_take,
		.empty, .pop, .dist_value, .degenerate);
endmodule

FILE: src/vdu_front.sv
// ----------------------------------------------------------------------------
// vdu_front: element-pair accumulator
// Takes one pair per cycle, while full is low, through a product stage and emits
// a request per finished vector into a two-entry queue.
// ----------------------------------------------------------------------------
module vdu_front import vdu_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [ElemBits-1:0] a_elem,
	input  logic signed [ElemBits-1:0] b_elem,
	input  logic                       use_cosine,
	input  logic [LenBits-1:0]         vector_length,
	output logic                       req_valid,
	output vec_req_t                   req,
	input  logic                       req_take
);
	logic                          v_s1;
	logic signed [2*ElemBits-1:0]  ab_s1;
	logic [2*ElemBits-1:0]         aa_s1, bb_s1;
	logic [2*ElemBits+1:0]         dd_s1;
	logic                          last_s1;
	logic signed [DotBits-1:0]     dot_q;
	logic [NormBits-1:0]           na_q, nb_q;
	logic [SqBits-1:0]             sq_q;
	logic [CntBits-1:0]            cnt_q;
	logic [LenBits-1:0]            len_eff;
	logic signed [ElemBits:0]      diff;
	logic signed [DotBits-1:0]     dot_n;
	logic [NormBits-1:0]           na_n, nb_n;
	logic [SqBits-1:0]             sq_n;
	logic                          acc;
	vec_req_t                      fifo_q [2];
	logic                          wp_q, rp_q;
	logic [1:0]                    fill_q;
	logic                          fpush;

	assign acc = push && !full;
	// room for the product stage entry that is about to be pushed
	assign full = (fill_q == 2'd2) || (fill_q == 2'd1 && v_s1 && last_s1);
	always_comb begin
		len_eff = vector_length;
		if (vector_length == '0) len_eff = LenBits'(1);
		if (vector_length > LenBits'(MaxLength)) len_eff = LenBits'(MaxLength);
	end
	assign diff = ElemBits'(0) + ($signed({a_elem[ElemBits-1], a_elem})
		- $signed({b_elem[ElemBits-1], b_elem}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			cnt_q <= '0;
		end else begin
			v_s1 <= acc;
			if (acc) begin
				last_s1 <= ({1'b0, cnt_q} + 1'b1) >= len_eff;
				cnt_q <= (({1'b0, cnt_q} + 1'b1) >= len_eff) ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ab_s1 <= a_elem * b_elem;
			aa_s1 <= (2*ElemBits)'(a_elem * a_elem);
			bb_s1 <= (2*ElemBits)'(b_elem * b_elem);
			dd_s1 <= (2*ElemBits+2)'(diff * diff);
		end
	end

	always_comb begin
		dot_n = dot_q + DotBits'(ab_s1);
		na_n = na_q + NormBits'(aa_s1);
		nb_n = nb_q + NormBits'(bb_s1);
		sq_n = sq_q + SqBits'(dd_s1);
	end

	assign fpush = v_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q <= '0;
			nb_q <= '0;
			sq_q <= '0;
		end else if (v_s1) begin
			dot_q <= last_s1 ? '0 : dot_n;
			na_q <= last_s1 ? '0 : na_n;
			nb_q <= last_s1 ? '0 : nb_n;
			sq_q <= last_s1 ? '0 : sq_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fpush) fifo_q[wp_q] <= '{cosine: use_cosine, dot: dot_n, norm_a: na_n,
			norm_b: nb_n, sq: sq_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (fpush) wp_q <= ~wp_q;
			if (req_take && req_valid) rp_q <= ~rp_q;
			fill_q <= fill_q + {1'b0, fpush} - {1'b0, req_take && req_valid};
		end
	end

	assign req_valid = fill_q != '0;
	assign req = fifo_q[rp_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'd2) else $error("request queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		fpush |-> (fill_q != 2'd2 || req_take)) else $error("push into full queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} < LenBits'(MaxLength)) else $error("count out of range");
endmodule

FILE: src/vdu_back.sv
// ----------------------------------------------------------------------------
// vdu_back: distance finisher
// Sequencer: norm product by 21/20-bit partials, bit-serial square root,
// restoring divide, then cosine saturation into a one-entry result register.
// ----------------------------------------------------------------------------
module vdu_back import vdu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  vec_req_t              req,
	output logic                  req_take,
	output logic                  empty,
	input  logic                  pop,
	output logic [DistBits-1:0]   dist_value,
	output logic                  degenerate
);
	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ROOT, S_DIV, S_FIN, S_OUT} state_t;
	state_t                 state_q;
	vec_req_t               r_q;
	logic [ProdBits-1:0]    p_q;
	logic [1:0]             part_q;
	logic [6:0]             step_q;
	logic [RootBits-1:0]    root_q;
	logic [ProdBits-1:0]    rem_q;
	logic [DotBits-1:0]     mag_q;
	logic [QuotBits-1:0]    quo_q;
	logic [RootBits:0]      drem_q;
	logic [DistBits-1:0]    dist_q;
	logic                   degen_q;
	logic [20:0]            xa;
	logic [20:0]            xb;
	logic [41:0]            pp;
	logic [ProdBits+1:0]    trial;
	logic [ProdBits+1:0]    rem_sh;
	logic [RootBits+1:0]    dsh;
	logic                   nbit;
	logic                   qbit;
	logic [QuotBits:0]      qsh;
	logic [DotBits+29:0]    num;
	logic signed [QuotBits+1:0] res;

	// 41-bit norms split into 21/20-bit halves: four partial products
	assign xa = part_q[1] ? 21'(r_q.norm_a[NormBits-1:21]) : r_q.norm_a[20:0];
	assign xb = part_q[0] ? 21'(r_q.norm_b[NormBits-1:21]) : r_q.norm_b[20:0];
	assign pp = xa * xb;
	// root: two bits of the radicand per step
	assign rem_sh = {rem_q, p_q[ProdBits-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign num = {mag_q, 30'b0};
	assign nbit = num[step_q];
	assign dsh = {drem_q, nbit};
	assign qbit = dsh >= {1'b0, root_q};
	// quotient is capped: once above the cap it stays there
	assign qsh = {quo_q, qbit};
	assign res = $signed({2'b0, OneQ30[QuotBits-1:0]})
		- (r_q.dot[DotBits-1] ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q}));

	assign req_take = state_q == S_IDLE && req_valid;
	assign empty = state_q != S_OUT;
	assign dist_value = dist_q;
	assign degenerate = degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			part_q <= '0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						r_q <= req;
						p_q <= '0;
						part_q <= '0;
						state_q <= req.cosine ? S_MUL : S_FIN;
					end
				end
				S_MUL: begin
					p_q <= p_q + (ProdBits'(pp) << (21 * (part_q[0] + part_q[1])));
					part_q <= part_q + 1'b1;
					if (part_q == 2'd3) begin
						state_q <= S_ROOT;
						step_q <= 7'(ProdBits / 2 - 1);
						root_q <= '0;
						rem_q <= '0;
					end
				end
				S_ROOT: begin
					// degenerate norms leave with the step count untouched
					if (step_q == 7'(ProdBits / 2 - 1) && p_q < DegenLimit) begin
						state_q <= S_FIN;
					end else begin
						if (rem_sh >= trial) begin
							rem_q <= ProdBits'(rem_sh - trial);
							root_q <= {root_q[RootBits-2:0], 1'b1};
						end else begin
							rem_q <= ProdBits'(rem_sh);
							root_q <= {root_q[RootBits-2:0], 1'b0};
						end
						p_q <= p_q << 2;
						if (step_q == '0) begin
							state_q <= S_DIV;
							step_q <= 7'(DotBits + 29);
							drem_q <= '0;
							quo_q <= '0;
							mag_q <= r_q.dot[DotBits-1] ? DotBits'(-r_q.dot) : r_q.dot;
						end else begin
							step_q <= step_q - 1'b1;
						end
					end
				end
				S_DIV: begin
					drem_q <= qbit ? (RootBits+1)'(dsh - {1'b0, root_q})
						: (RootBits+1)'(dsh);
					quo_q <= (qsh > {1'b0, QCap}) ? QCap : qsh[QuotBits-1:0];
					if (step_q == '0) state_q <= S_FIN;
					else step_q <= step_q - 1'b1;
				end
				S_FIN: begin
					// p_q still holds the raw product only on the degenerate exit
					if (!r_q.cosine) begin
						dist_q <= r_q.sq;
						degen_q <= 1'b0;
					end else if (step_q == 7'(ProdBits / 2 - 1)) begin
						dist_q <= OneQ30;
						degen_q <= 1'b1;
					end else begin
						degen_q <= 1'b0;
						if (res < 0) dist_q <= '0;
						else if (res > $signed({1'b0, TwoQ30})) dist_q <= TwoQ30;
						else dist_q <= DistBits'(res);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (pop) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> state_q != S_IDLE) else $error("request taken but no work");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !pop) |=> $stable(dist_q)) else $error("result changed");
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && r_q.cosine) |-> dist_q <= TwoQ30) else $error("cos range");
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for vector_distance_unit
// Streams element pairs through the push/full side, drains distances through
// empty/pop, and compares each against a table value or an in-bench predictor.
// A short table of directed pairs runs first, then randomized vector phases
// that move the length and mode between phases, mid-vector included.
// ----------------------------------------------------------------------------
module tb;
	import vdu_pkg::*;

	typedef struct {
		logic signed [ElemBits-1:0] a;
		logic signed [ElemBits-1:0] b;
		bit                         has_exp;
		logic [DistBits-1:0]        dval;
		bit                         degen;
	} pair_t;

	typedef struct {
		logic [DistBits-1:0] dval;
		bit                  degen;
	} dist_t;

	typedef struct {
		bit                         cosine;
		logic [LenBits-1:0]         len;
		logic signed [ElemBits-1:0] a;
		logic signed [ElemBits-1:0] b;
		bit                         has_exp;
		logic [DistBits-1:0]        dval;
		bit                         degen;
	} row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic                       full;
	logic signed [ElemBits-1:0] a_elem = '0;
	logic signed [ElemBits-1:0] b_elem = '0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic [DistBits-1:0]        dist_value;
	logic                       degenerate;
	logic                       cfg_we = 1'b0;
	logic [RegIdxBits-1:0]      cfg_index = REG_USE_COSINE;
	logic [CfgDataBits-1:0]     cfg_data = '0;

	vector_distance_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pair_t pair_q[$];
	dist_t dist_q[$];
	int    errors = 0;
	int    gap_pct = 10;
	int    stall_pct = 71;
	int    quiet = 0;

	// predictor state
	bit                 m_cosine = 1'b0;
	logic [LenBits-1:0] m_len = LenBits'(128);
	longint             m_dot = 0;
	longint unsigned    m_na = 0, m_nb = 0, m_sq = 0;
	int                 m_cnt = 0;

	function automatic bit predict_distance(input logic signed [ElemBits-1:0] a,
			input logic signed [ElemBits-1:0] b, output dist_t res);
		longint          av, bv, dv, eff, r;
		logic [127:0]    p, root, c, mag, q;
		av = a;
		bv = b;
		dv = av - bv;
		eff = (m_len == 0) ? 1 : (m_len > MaxLength) ? MaxLength : m_len;
		m_dot += av * bv;
		m_na += av * av;
		m_nb += bv * bv;
		m_sq += dv * dv;
		m_cnt++;
		res.dval = '0;
		res.degen = 1'b0;
		if (m_cnt < eff)
			return 1'b0;
		if (m_cosine) begin
			p = 128'(m_na) * 128'(m_nb);
			if (p < 116) begin
				res.dval = DistBits'(1) << 30;
				res.degen = 1'b1;
			end else begin
				root = '0;
				for (int i = 62; i >= 0; i--) begin
					c = root | (128'(1) << i);
					if (c * c <= p)
						root = c;
				end
				mag = (m_dot < 0) ? 128'(-m_dot) : 128'(m_dot);
				q = (mag << 30) / root;
				if (q > (128'(1) << 40))
					q = 128'(1) << 40;
				r = (longint'(1) << 30) - ((m_dot < 0) ? -longint'(q) : longint'(q));
				if (r < 0)
					r = 0;
				if (r > (longint'(1) << 31))
					r = longint'(1) << 31;
				res.dval = DistBits'(r);
			end
		end else begin
			res.dval = (m_sq > 64'((64'(1) << 43) - 1)) ? {DistBits{1'b1}} : DistBits'(m_sq);
		end
		m_dot = 0;
		m_na = 0;
		m_nb = 0;
		m_sq = 0;
		m_cnt = 0;
		return 1'b1;
	endfunction

	// request side
	always @(posedge clk) begin
		pair_t cur;
		dist_t res;
		if (push && !full) begin
			cur = pair_q.pop_front();
			if (predict_distance(a_elem, b_elem, res)) begin
				if (cur.has_exp) begin
					res.dval = cur.dval;
					res.degen = cur.degen;
				end
				dist_q.insert(dist_q.size(), res);
			end
		end
		if (pair_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
			push <= 1'b1;
			a_elem <= pair_q[0].a;
			b_elem <= pair_q[0].b;
		end else begin
			push <= 1'b0;
		end
	end

	// result side
	always @(posedge clk) begin
		dist_t want;
		if (pop && !empty) begin
			if (dist_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result dist=%0d degen=%0b", dist_value, degenerate);
			end else begin
				want = dist_q.pop_front();
				if (dist_value !== want.dval || degenerate !== want.degen) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: dist exp %0d got %0d, degen exp %0b got %0b",
							want.dval, dist_value, want.degen, degenerate);
				end
			end
		end
		pop <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("[vector_distance_unit] ERROR");
			$finish;
		end
	end

	task automatic drain();
		wait (pair_q.size() == 0 && dist_q.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [RegIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_USE_COSINE)
			m_cosine = val[0];
		else
			m_len = val[LenBits-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_pair(input logic signed [ElemBits-1:0] a, input logic signed [ElemBits-1:0] b);
		pair_t p;
		p.a = a;
		p.b = b;
		p.has_exp = 1'b0;
		p.dval = '0;
		p.degen = 1'b0;
		pair_q.insert(pair_q.size(), p);
	endtask

	function automatic logic signed [ElemBits-1:0] pick_elem(input int style);
		case (style)
			0: return ElemBits'($signed($urandom_range(4)) - 2);
			1: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
			default: return ElemBits'($urandom);
		endcase
	endfunction

	localparam logic [DistBits-1:0] ONE = DistBits'(1) << 30;
	localparam logic [DistBits-1:0] TWO = DistBits'(1) << 31;

	row_t rows[] = '{
		'{0, 1, 16'sh7fff, -16'sh8000, 1, 43'd4294836225, 0},
		'{0, 1, -16'sh8000, -16'sh8000, 1, 0, 0},
		'{0, 1, 16'sh0000, 16'sh0000, 1, 0, 0},
		'{0, 1, -16'sh8000, 16'sh7fff, 1, 43'd4294836225, 0},
		'{0, 0, 16'sh0003, -16'sh0002, 1, 25, 0},
		'{0, 0, 16'sh1234, 16'sh4321, 0, 0, 0},
		'{1, 1, 16'sh0000, 16'sh0000, 1, ONE, 1},
		'{1, 1, 16'sh0001, 16'sh0001, 1, ONE, 1},
		'{1, 1, 16'sh4000, 16'sh4000, 1, 0, 0},
		'{1, 1, 16'sh4000, -16'sh4000, 1, TWO, 0},
		'{1, 1, -16'sh8000, -16'sh8000, 1, 0, 0},
		'{1, 1, 16'sh7fff, -16'sh8000, 1, TWO, 0},
		'{1, 1, 16'sh7fff, 16'sh0000, 1, ONE, 1},
		'{1, 1, 16'sh000b, 16'sh000b, 0, 0, 0},
		'{1, 1, 16'sh0123, -16'sh0456, 0, 0, 0},
		'{1, 2, 16'sh3000, 16'sh1000, 0, 0, 0},
		'{1, 2, -16'sh2000, 16'sh7000, 0, 0, 0}
	};

	initial begin
		bit cur_cos, big_done;
		int eff, count, style, mode;
		logic [LenBits-1:0] len, cur_len;
		pair_t p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		cur_cos = 1'b0;
		cur_len = LenBits'(128);
		big_done = 1'b0;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].cosine != cur_cos || rows[i].len != cur_len || i == 0) begin
				drain();
				write_reg(REG_USE_COSINE, CfgDataBits'(rows[i].cosine));
				write_reg(REG_VECTOR_LENGTH, CfgDataBits'(rows[i].len));
				cur_cos = rows[i].cosine;
				cur_len = rows[i].len;
			end
			p.a = rows[i].a;
			p.b = rows[i].b;
			p.has_exp = rows[i].has_exp;
			p.dval = rows[i].dval;
			p.degen = rows[i].degen;
			pair_q.insert(pair_q.size(), p);
		end

		count = 0;
		while (count < 2000) begin
			mode = (count < 700) ? 0 : (count < 1400) ? 1 : 2;
			gap_pct = (mode == 0) ? 10 : (mode == 1) ? 71 : 0;
			stall_pct = (mode == 0) ? 71 : (mode == 1) ? 10 : 0;
			case ($urandom_range(9))
				0: len = LenBits'(0);
				1: len = LenBits'(1);
				2: len = big_done ? LenBits'(7) : LenBits'(2047);
				3: len = big_done ? LenBits'(3) : LenBits'(1024);
				4: len = LenBits'($urandom_range(13, 64));
				default: len = LenBits'($urandom_range(2, 12));
			endcase
			if (len >= 1024)
				big_done = 1'b1;
			drain();
			write_reg(REG_USE_COSINE, CfgDataBits'($urandom_range(1)));
			write_reg(REG_VECTOR_LENGTH, CfgDataBits'(len));
			eff = (len == 0) ? 1 : (len > MaxLength) ? MaxLength : len;
			// leftover pairs carry a partial vector into the next setting
			eff = (eff >= 1024) ? eff + $urandom_range(10)
				: eff * $urandom_range(1, 4) + $urandom_range(eff - 1);
			style = $urandom_range(4);
			repeat (eff) begin
				logic signed [ElemBits-1:0] a;
				a = pick_elem((style < 3) ? style : 2);
				case (style)
					3: add_pair(a, ($urandom_range(9) == 0) ? pick_elem(2) : a);
					4: add_pair(a, ($urandom_range(9) == 0) ? pick_elem(2) : -a);
					default: add_pair(a, pick_elem(($urandom_range(7) == 0) ? 2 : style));
				endcase
				count++;
			end
		end
		wait (pair_q.size() == 0 && dist_q.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && dist_q.size() == 0)
			$display("[vector_distance_unit] OK");
		else
			$display("[vector_distance_unit] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
src/vdu_pkg.sv
src/vdu_front.sv
src/vdu_back.sv
src/vector_distance_unit.sv
verif/tb.sv
